// File: design/ppar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppar_pkg
// shared constants and types for the progressive pixel accumulate resolve block
// ----------------------------------------------------------------------------
package ppar_pkg;

  localparam int unsigned PixelCountDef   = 65536;
  localparam int unsigned FracBitsDef     = 12;
  localparam int unsigned SumW            = 32;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned PixW            = 16;
  localparam int unsigned FramesW         = 16;
  localparam int unsigned LimitW          = 33;
  localparam int unsigned ByteW           = 8;
  localparam logic [15:0] GammaScale      = 16'd65025;
  localparam logic [7:0]  AlphaOpaque     = 8'hFF;

  // frame settings as seen by the datapath
  typedef struct packed {
    logic                 restart;
    logic [FramesW-1:0]   frames;
    logic [LimitW-1:0]    limit;   // frames * (one + 1): any sum at or above clamps
  } ppar_cfg_t;

endpackage

// File: design/ppar_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppar_accum
// per-pixel rgb accumulator memory with read-modify-write and forwarding
// ----------------------------------------------------------------------------
module ppar_accum #(
  parameter int unsigned PIXEL_COUNT = ppar_pkg::PixelCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ppar_pkg::PixW-1:0]     pixel_i,
  input  logic [ppar_pkg::SampleW-1:0]  red_i,
  input  logic [ppar_pkg::SampleW-1:0]  green_i,
  input  logic [ppar_pkg::SampleW-1:0]  blue_i,
  input  logic                          restart_i,
  output logic                          valid_o,
  output logic [ppar_pkg::PixW-1:0]     pixel_o,
  output logic [ppar_pkg::SumW-1:0]     red_sum_o,
  output logic [ppar_pkg::SumW-1:0]     green_sum_o,
  output logic [ppar_pkg::SumW-1:0]     blue_sum_o
);
  import ppar_pkg::*;

  localparam int unsigned AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned MemW = 3 * SumW;

  logic [MemW-1:0] mem [PIXEL_COUNT];

  logic [31:0]       pix_ext;
  logic [AW-1:0]     addr;
  logic              in_range;

  logic              vld1_q, inr1_q;
  logic [AW-1:0]     addr1_q;
  logic [PixW-1:0]   pix1_q;
  logic [SampleW-1:0] r1_q, g1_q, b1_q;
  logic [MemW-1:0]   rd_q;

  logic              vld2_q, wr2_q;
  logic [AW-1:0]     addr2_q;
  logic [PixW-1:0]   pix2_q;
  logic [MemW-1:0]   sum_q, sum_d, old;
  logic              fwd, we;

  assign pix_ext  = 32'(pixel_i);
  assign addr     = pix_ext[AW-1:0];
  assign in_range = pix_ext < 32'(PIXEL_COUNT);

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [SampleW-1:0] s);
    logic [SumW:0] t;
    t = {1'b0, a} + (SumW+1)'(s);
    return t[SumW] ? {SumW{1'b1}} : t[SumW-1:0];
  endfunction

  // the item ahead was written back at the edge this entry was read
  assign fwd = wr2_q && (addr2_q == addr1_q);

  always_comb begin
    old = fwd ? sum_q : rd_q;
    if (restart_i || !inr1_q) begin
      old = '0;
    end
    sum_d = {sat_add(old[3*SumW-1:2*SumW], b1_q),
             sat_add(old[2*SumW-1:SumW], g1_q),
             sat_add(old[SumW-1:0], r1_q)};
  end

  assign we = en_i && vld1_q && inr1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= mem[addr];
    end
    if (we) begin
      mem[addr1_q] <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      wr2_q  <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      wr2_q  <= vld1_q && inr1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inr1_q  <= in_range;
      addr1_q <= addr;
      pix1_q  <= pixel_i;
      r1_q    <= red_i;
      g1_q    <= green_i;
      b1_q    <= blue_i;
      addr2_q <= addr1_q;
      pix2_q  <= pix1_q;
      sum_q   <= sum_d;
    end
  end

  assign valid_o     = vld2_q;
  assign pixel_o     = pix2_q;
  assign red_sum_o   = sum_q[SumW-1:0];
  assign green_sum_o = sum_q[2*SumW-1:SumW];
  assign blue_sum_o  = sum_q[3*SumW-1:2*SumW];

endmodule

// File: design/ppar_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppar_resolve
// one channel: pipelined divide by frame count, clamp, then gamma-2 byte
// ----------------------------------------------------------------------------
module ppar_resolve #(
  parameter int unsigned SAMPLE_FRACTION_BITS = ppar_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  ppar_pkg::ppar_cfg_t         cfg_i,
  input  logic [ppar_pkg::SumW-1:0]   sum_i,
  output logic [ppar_pkg::ByteW-1:0]  byte_o
);
  import ppar_pkg::*;

  localparam int unsigned QW = SAMPLE_FRACTION_BITS + 1;
  localparam int unsigned TW = SAMPLE_FRACTION_BITS + 17;
  localparam logic [QW-1:0] One = QW'(1) << SAMPLE_FRACTION_BITS;

  logic [SumW-1:0] rem_q  [QW+1];
  logic [QW-1:0]   quo_q  [QW+1];
  logic            clamp_q[QW+1];
  logic [TW-1:0]   tgt_q  [9];
  logic [ByteW-1:0] b_q   [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= sum_i;
      quo_q[0]   <= '0;
      clamp_q[0] <= LimitW'(sum_i) >= cfg_i.limit;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned K = QW - 1 - j;
    logic [LimitW-1:0] dvs;
    assign dvs = LimitW'(cfg_i.frames) << K;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        clamp_q[j+1] <= clamp_q[j];
        if (!clamp_q[j] && (LimitW'(rem_q[j]) >= dvs)) begin
          rem_q[j+1] <= rem_q[j] - dvs[SumW-1:0];
          quo_q[j+1] <= quo_q[j] | (QW'(1) << K);
        end else begin
          rem_q[j+1] <= rem_q[j];
          quo_q[j+1] <= quo_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tgt_q[0] <= TW'(GammaScale) * TW'(clamp_q[QW] ? One : quo_q[QW]);
      b_q[0]   <= '0;
    end
  end

  // square root by trial bits, largest b with b*b*one <= 65025*value
  for (genvar i = 0; i < 8; i++) begin : g_sqrt
    localparam int unsigned Bit = 7 - i;
    logic [ByteW-1:0] trial;
    logic [15:0]      sq;
    assign trial = b_q[i] | (ByteW'(1) << Bit);
    assign sq    = 16'(trial) * 16'(trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tgt_q[i+1] <= tgt_q[i];
        b_q[i+1]   <= ((TW'(sq) << SAMPLE_FRACTION_BITS) <= tgt_q[i]) ? trial : b_q[i];
      end
    end
  end

  assign byte_o = b_q[8];

endmodule

// File: design/progressive_pixel_accumulate_resolve_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// progressive_pixel_accumulate_resolve_top
// progressive frame accumulation with gamma-2 resolve to packed rgba
// ----------------------------------------------------------------------------
// Takes one pixel beat per cycle unless the output is stalled, and returns
// one packed colour per beat, in order. Throughput is set by the
// accumulator memory: one read and one write port, each used once per beat,
// with the previous beat's sum forwarded when the same pixel follows
// directly. The divider and square root are fully pipelined, one bit per
// stage. Accumulator contents are undefined after reset; write frame_count
// only while no beats are in flight.
module progressive_pixel_accumulate_resolve_top #(
  parameter int unsigned PIXEL_COUNT          = ppar_pkg::PixelCountDef,
  parameter int unsigned SAMPLE_FRACTION_BITS = ppar_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppar_pkg::FramesW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ppar_pkg::PixW-1:0]     pixel_number_i,
  input  logic [ppar_pkg::SampleW-1:0]  red_sample_i,
  input  logic [ppar_pkg::SampleW-1:0]  green_sample_i,
  input  logic [ppar_pkg::SampleW-1:0]  blue_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppar_pkg::PixW-1:0]     out_pixel_number_o,
  output logic [31:0]                   packed_color_o
);
  import ppar_pkg::*;

  localparam int unsigned ResLat = SAMPLE_FRACTION_BITS + 11;
  localparam logic [LimitW-1:0] OnePlus = LimitW'((1 << SAMPLE_FRACTION_BITS) + 1);

  logic              en;
  logic [FramesW-1:0] frames_q;
  logic              restart_q;
  logic [LimitW-1:0] limit_q;
  ppar_cfg_t         cfg;

  logic              acc_vld;
  logic [PixW-1:0]   acc_pix;
  logic [SumW-1:0]   r_sum, g_sum, b_sum;
  logic [ByteW-1:0]  r_byte, g_byte, b_byte;

  logic              vld_q [ResLat];
  logic [PixW-1:0]   pix_q [ResLat];

  // whole pipeline advances unless a finished beat is held at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en && rst_ni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q  <= FramesW'(1);
      restart_q <= 1'b1;
    end else if (cfg_we_i) begin
      // zero frames behaves as a restart
      frames_q  <= (cfg_wdata_i == '0) ? FramesW'(1) : cfg_wdata_i;
      restart_q <= (cfg_wdata_i == FramesW'(1)) || (cfg_wdata_i == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= LimitW'(frames_q) * OnePlus;
  end

  assign cfg = '{restart: restart_q, frames: frames_q, limit: limit_q};

  ppar_accum #(.PIXEL_COUNT(PIXEL_COUNT)) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .pixel_i     (pixel_number_i),
    .red_i       (red_sample_i),
    .green_i     (green_sample_i),
    .blue_i      (blue_sample_i),
    .restart_i   (cfg.restart),
    .valid_o     (acc_vld),
    .pixel_o     (acc_pix),
    .red_sum_o   (r_sum),
    .green_sum_o (g_sum),
    .blue_sum_o  (b_sum)
  );

  ppar_resolve #(.SAMPLE_FRACTION_BITS(SAMPLE_FRACTION_BITS)) u_res_r (
    .clk_i(clk_i), .en_i(en), .cfg_i(cfg), .sum_i(r_sum), .byte_o(r_byte)
  );
  ppar_resolve #(.SAMPLE_FRACTION_BITS(SAMPLE_FRACTION_BITS)) u_res_g (
    .clk_i(clk_i), .en_i(en), .cfg_i(cfg), .sum_i(g_sum), .byte_o(g_byte)
  );
  ppar_resolve #(.SAMPLE_FRACTION_BITS(SAMPLE_FRACTION_BITS)) u_res_b (
    .clk_i(clk_i), .en_i(en), .cfg_i(cfg), .sum_i(b_sum), .byte_o(b_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ResLat; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= acc_vld;
      for (int i = 1; i < ResLat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[0] <= acc_pix;
      for (int i = 1; i < ResLat; i++) begin
        pix_q[i] <= pix_q[i-1];
      end
    end
  end

  assign out_valid_o        = vld_q[ResLat-1];
  assign out_pixel_number_o = pix_q[ResLat-1];
  assign packed_color_o     = {AlphaOpaque, b_byte, g_byte, r_byte};

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_pixel_number_o))
    else $error("output beat lost while stalled");

  a_frames_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q != '0)
    else $error("frame count register holds zero");

  a_restart_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_q == (frames_q == FramesW'(1)))
    else $error("restart flag disagrees with frame count");

endmodule
